### rtl/core/stepper_reply_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Reply frame parser assertion macros
// Concurrent checks, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH
`define STEPPER_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SRFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srfp assertion failed");

// next-cycle implication
`define SRFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srfp assertion failed");

`else

`define SRFP_ASSERT_NOW(lbl, ante, cons)
`define SRFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/srfp_pkg.sv
// ----------------------------------------------------------------------------
// srfp_pkg
// Types, codes and helper functions of the stepper reply frame parser.
// ----------------------------------------------------------------------------
package srfp_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } srfp_in_t;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [7:0]  func_code;
    logic        negative;
    logic [31:0] magnitude;
    logic        last;
  } srfp_out_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [1:0]  checksum_mode;
    logic [15:0] byte_gap_ticks;
  } srfp_cfg_t;

  // result job handed from the parser to the output stage
  typedef struct packed {
    logic      valid;
    logic      multi;
    srfp_out_t res;
  } srfp_job_t;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP_TICKS = 2'd2;

  localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
  localparam logic [1:0]  RST_CHECKSUM_MODE  = 2'd0;
  localparam logic [15:0] RST_BYTE_GAP_TICKS = 16'd50;

  // checksum modes
  localparam logic [1:0] CHK_FIXED = 2'd0;
  localparam logic [1:0] CHK_XOR   = 2'd1;
  localparam logic [1:0] CHK_CRC   = 2'd2;
  localparam logic [7:0] CHK_FIXED_BYTE = 8'h6B;
  localparam logic [7:0] CRC_POLY       = 8'h8C;

  // commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // field ids
  localparam logic [3:0] FID_BAD      = 4'd0;
  localparam logic [3:0] FID_NODATA   = 4'd1;
  localparam logic [3:0] FID_STATUS   = 4'd2;
  localparam logic [3:0] FID_POSITION = 4'd3;
  localparam logic [3:0] FID_SPEED    = 4'd4;
  localparam logic [3:0] FID_TARGET   = 4'd5;
  localparam logic [3:0] FID_CUR_TGT  = 4'd6;
  localparam logic [3:0] FID_ERROR    = 4'd7;
  localparam logic [3:0] FID_VERSION  = 4'd8;
  localparam logic [3:0] FID_BUS_MV   = 4'd9;
  localparam logic [3:0] FID_PHASE_MA = 4'd10;
  localparam logic [3:0] FID_ENCODER  = 4'd11;
  localparam logic [3:0] FID_READY    = 4'd12;
  localparam logic [3:0] FID_MOTOR    = 4'd13;

  // bad frame reasons
  localparam logic [31:0] BAD_TIMEOUT  = 32'd0;
  localparam logic [31:0] BAD_UNKNOWN  = 32'd1;
  localparam logic [31:0] BAD_CHECKSUM = 32'd2;

  // function codes
  localparam logic [7:0] FN_STAT_FD = 8'hFD;
  localparam logic [7:0] FN_STAT_F3 = 8'hF3;
  localparam logic [7:0] FN_STAT_F6 = 8'hF6;
  localparam logic [7:0] FN_STAT_FE = 8'hFE;
  localparam logic [7:0] FN_NODATA  = 8'h32;
  localparam logic [7:0] FN_TARGET  = 8'h33;
  localparam logic [7:0] FN_CUR_TGT = 8'h34;
  localparam logic [7:0] FN_SPEED   = 8'h35;
  localparam logic [7:0] FN_POS     = 8'h36;
  localparam logic [7:0] FN_ERROR   = 8'h37;
  localparam logic [7:0] FN_SYSTEM  = 8'h43;

  localparam logic [5:0] LEN_STATUS = 6'd4;
  localparam logic [5:0] LEN_WORD   = 6'd8;
  localparam logic [5:0] LEN_SPEED  = 6'd6;
  localparam logic [5:0] LEN_SYSTEM = 6'd31;
  localparam logic [5:0] LEN_NONE   = 6'd0;

  // system-state frame: bytes 2..29 carry the fields
  localparam int SYS_FIRST_BYTE = 2;
  localparam int SYS_BYTES      = 28;
  localparam logic [3:0] SYS_LAST_IDX = 4'd9;
  typedef logic [SYS_BYTES-1:0][7:0] srfp_sys_t;

  // reflected CRC-8, one byte
  function automatic logic [7:0] crc_step(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // total frame length from the function code, zero when unknown
  function automatic logic [5:0] frame_len(input logic [7:0] fn);
    logic [5:0] len;
    case (fn)
      FN_STAT_FD, FN_STAT_F3, FN_STAT_F6, FN_STAT_FE: len = LEN_STATUS;
      FN_NODATA, FN_TARGET, FN_CUR_TGT, FN_POS, FN_ERROR: len = LEN_WORD;
      FN_SPEED:  len = LEN_SPEED;
      FN_SYSTEM: len = LEN_SYSTEM;
      default:   len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/srfp_parse.sv
// ----------------------------------------------------------------------------
// srfp_parse
// Byte and tick parser: frame sync, frame store, running checksum and
// single-result decode. Raises one job per input that causes results.
// ----------------------------------------------------------------------------
`include "stepper_reply_frame_parser_unit_assert.svh"

module srfp_parse #(
  parameter int MAX_FRAME_BYTES = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  srfp_pkg::srfp_in_t  in_data,
  input  srfp_pkg::srfp_cfg_t cfg,
  output srfp_pkg::srfp_job_t job_o,
  output srfp_pkg::srfp_sys_t sys_bytes_o
);
  import srfp_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SA_W  = $clog2(MAX_FRAME_BYTES);
  localparam int EXT   = (MAX_FRAME_BYTES > 30) ? MAX_FRAME_BYTES : 30;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_FRAME_BYTES);
  localparam logic [6:0]       MAX_LEN = 7'(MAX_FRAME_BYTES);

  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_FUNC = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [IDX_W-1:0] frame_len_r, frame_len_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [7:0]       run_xor_r, run_xor_nxt;
  logic [7:0]       run_crc_r, run_crc_nxt;

  logic [7:0] frame_store_r [MAX_FRAME_BYTES];
  logic [7:0] fs_ext [EXT];

  logic            store_we;
  logic [SA_W-1:0] store_addr;

  logic [7:0]       rx;
  logic [5:0]       code_len;
  logic [IDX_W-1:0] byte_inc;
  logic [16:0]      idle_inc;
  logic [7:0]       chk_want;
  logic [7:0]       fn_st;
  srfp_out_t        single;
  srfp_job_t        job;

  // fixed-place view of the store; bytes beyond the store read as zero
  for (genvar i = 0; i < EXT; i++) begin : g_ext
    if (i < MAX_FRAME_BYTES) begin : g_in
      assign fs_ext[i] = frame_store_r[i];
    end else begin : g_out
      assign fs_ext[i] = 8'h00;
    end
  end

  for (genvar j = 0; j < SYS_BYTES; j++) begin : g_sys
    assign sys_bytes_o[j] = fs_ext[j + SYS_FIRST_BYTE];
  end

  assign rx       = in_data.rx_byte;
  assign code_len = frame_len(rx);
  assign byte_inc = byte_index_r + 1'b1;
  assign idle_inc = {1'b0, idle_r} + 17'd1;
  assign fn_st    = fs_ext[1];

  always_comb begin
    case (cfg.checksum_mode)
      CHK_XOR: chk_want = run_xor_r;
      CHK_CRC: chk_want = run_crc_r;
      default: chk_want = CHK_FIXED_BYTE;
    endcase
  end

  // decode of every frame that yields exactly one field
  always_comb begin
    single           = '0;
    single.func_code = fn_st;
    single.last      = 1'b1;
    single.negative  = (fs_ext[2] != 8'h00);
    single.magnitude = {fs_ext[3], fs_ext[4], fs_ext[5], fs_ext[6]};
    case (fn_st)
      FN_STAT_FD, FN_STAT_F3, FN_STAT_F6, FN_STAT_FE: begin
        single.field_id  = FID_STATUS;
        single.negative  = 1'b0;
        single.magnitude = {24'd0, fs_ext[2]};
      end
      FN_POS:     single.field_id = FID_POSITION;
      FN_TARGET:  single.field_id = FID_TARGET;
      FN_CUR_TGT: single.field_id = FID_CUR_TGT;
      FN_ERROR:   single.field_id = FID_ERROR;
      FN_SPEED: begin
        single.field_id  = FID_SPEED;
        single.magnitude = {16'd0, fs_ext[3], fs_ext[4]};
      end
      default: begin
        single.field_id  = FID_NODATA;
        single.negative  = 1'b0;
        single.magnitude = '0;
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_index_nxt = byte_index_r;
    frame_len_nxt  = frame_len_r;
    idle_nxt       = idle_r;
    run_xor_nxt    = run_xor_r;
    run_crc_nxt    = run_crc_r;
    store_we       = 1'b0;
    store_addr     = byte_index_r[SA_W-1:0];
    job            = '0;
    job.res.last   = 1'b1;

    if (in_fire) begin
      if (in_data.cmd == CMD_TICK) begin
        if (phase_r != PH_ADDR) begin
          if (idle_inc > {1'b0, cfg.byte_gap_ticks}) begin
            job.valid         = 1'b1;
            job.res.field_id  = FID_BAD;
            job.res.func_code = (phase_r == PH_DATA) ? fn_st : 8'h00;
            job.res.magnitude = BAD_TIMEOUT;
            phase_nxt         = PH_ADDR;
            idle_nxt          = '0;
          end else begin
            idle_nxt = idle_inc[15:0];
          end
        end
      end else begin
        idle_nxt = '0;
        case (phase_r)
          PH_ADDR: begin
            if (rx == cfg.device_address) begin
              store_we    = 1'b1;
              store_addr  = '0;
              phase_nxt   = PH_FUNC;
              run_xor_nxt = rx;
              run_crc_nxt = rx;
            end
          end
          PH_FUNC: begin
            store_we   = 1'b1;
            store_addr = SA_W'(1);
            if (code_len == LEN_NONE || {1'b0, code_len} > MAX_LEN) begin
              job.valid         = 1'b1;
              job.res.field_id  = FID_BAD;
              job.res.func_code = rx;
              job.res.magnitude = BAD_UNKNOWN;
              phase_nxt         = PH_ADDR;
            end else begin
              frame_len_nxt  = IDX_W'(code_len);
              byte_index_nxt = IDX_W'(2);
              phase_nxt      = PH_DATA;
              run_xor_nxt    = run_xor_r ^ rx;
              run_crc_nxt    = crc_step(run_crc_r ^ rx);
            end
          end
          PH_DATA: begin
            store_we = (byte_index_r < MAX_IDX);
            if (byte_inc >= frame_len_r || byte_inc >= MAX_IDX) begin
              // checksum byte: verify and hand off the frame
              job.valid = 1'b1;
              if (rx != chk_want) begin
                job.res.field_id  = FID_BAD;
                job.res.func_code = fn_st;
                job.res.magnitude = BAD_CHECKSUM;
              end else if (fn_st == FN_SYSTEM) begin
                job.multi         = 1'b1;
                job.res.func_code = fn_st;
              end else begin
                job.res = single;
              end
              phase_nxt      = PH_ADDR;
              byte_index_nxt = '0;
            end else begin
              byte_index_nxt = byte_inc;
              run_xor_nxt    = run_xor_r ^ rx;
              run_crc_nxt    = crc_step(run_crc_r ^ rx);
            end
          end
          default: phase_nxt = PH_ADDR;
        endcase
      end
    end
  end

  assign job_o = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ADDR;
      byte_index_r <= '0;
      frame_len_r  <= '0;
      idle_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      frame_len_r  <= frame_len_nxt;
      idle_r       <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_xor_r <= run_xor_nxt;
    run_crc_r <= run_crc_nxt;
    if (store_we) begin
      frame_store_r[store_addr] <= rx;
    end
  end

  `SRFP_ASSERT_NOW(a_data_index_range, phase_r == PH_DATA, (byte_index_r >= IDX_W'(2)) && (byte_index_r < frame_len_r))
  `SRFP_ASSERT_NEXT(a_result_resyncs, job_o.valid, phase_r == PH_ADDR)

endmodule

### rtl/core/stepper_reply_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// stepper_reply_frame_parser_unit
// Reply frame parser for a stepper servo board on a serial line.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per received byte (cmd 0) or per 1 ms tick (cmd 1).
//   out_* : decoded field results; last marks the final beat of an input.
//   cfg_* : register writes (device address, checksum mode, byte gap);
//           cfg_ready is always high, index 3 is ignored.
// Flow: the accepted beat goes to a job register and its first result to the
//   output register once that is free. Throughput: one input beat per cycle
//   while no job waits, even for inputs without results; a single-result input
//   lets the next input in on the next cycle while out_ready is high.
// A system-state frame gives ten beats, on consecutive cycles while out_ready
//   is high, from a sequencer over the frame store; in_ready stays low until the
//   tenth beat loads the output register.
// Stall: out_ready low holds the output register and the pending job; in_ready
//   is low while a job waits, so no input passes until the job has loaded.
// Reset: registers go to defaults (address 1, fixed 0x6B check, 50 ticks)
//   and the parser waits for an address byte.
// ----------------------------------------------------------------------------
`include "stepper_reply_frame_parser_unit_assert.svh"

module stepper_reply_frame_parser_unit #(
  parameter int MAX_FRAME_BYTES = 31
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  srfp_pkg::srfp_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output srfp_pkg::srfp_out_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [srfp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srfp_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import srfp_pkg::*;

  srfp_cfg_t cfg_r;
  srfp_job_t new_job;
  srfp_sys_t sys_bytes;

  logic      job_valid_r, job_valid_nxt;
  logic      job_multi_r, job_multi_nxt;
  srfp_out_t job_res_r, job_res_nxt;
  logic [3:0] job_idx_r, job_idx_nxt;

  logic      out_valid_r;
  srfp_out_t out_r;
  srfp_out_t multi_res;
  srfp_out_t beat;

  logic load;
  logic job_done;
  logic in_fire;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= RST_DEVICE_ADDRESS;
      cfg_r.checksum_mode  <= RST_CHECKSUM_MODE;
      cfg_r.byte_gap_ticks <= RST_BYTE_GAP_TICKS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_data[7:0];
        REG_CHECKSUM_MODE:  cfg_r.checksum_mode  <= cfg_data[1:0];
        REG_BYTE_GAP_TICKS: cfg_r.byte_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  srfp_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .job_o      (new_job),
    .sys_bytes_o(sys_bytes)
  );

  assign load     = job_valid_r && (!out_valid_r || out_ready);
  assign job_done = load && (!job_multi_r || job_idx_r == SYS_LAST_IDX);
  assign in_ready = !job_valid_r || job_done;
  assign in_fire  = in_valid && in_ready;

  // system-state frame fields; sys_bytes[0] is frame byte 2
  always_comb begin
    multi_res           = '0;
    multi_res.func_code = job_res_r.func_code;
    multi_res.last      = (job_idx_r == SYS_LAST_IDX);
    case (job_idx_r)
      4'd0: begin
        multi_res.field_id  = FID_VERSION;
        multi_res.magnitude = {16'd0, sys_bytes[0], sys_bytes[1]};
      end
      4'd1: begin
        multi_res.field_id  = FID_BUS_MV;
        multi_res.magnitude = {16'd0, sys_bytes[2], sys_bytes[3]};
      end
      4'd2: begin
        multi_res.field_id  = FID_PHASE_MA;
        multi_res.magnitude = {16'd0, sys_bytes[4], sys_bytes[5]};
      end
      4'd3: begin
        multi_res.field_id  = FID_ENCODER;
        multi_res.magnitude = {16'd0, sys_bytes[6], sys_bytes[7]};
      end
      4'd4: begin
        multi_res.field_id  = FID_TARGET;
        multi_res.negative  = (sys_bytes[8] != 8'h00);
        multi_res.magnitude = {sys_bytes[9], sys_bytes[10], sys_bytes[11], sys_bytes[12]};
      end
      4'd5: begin
        multi_res.field_id  = FID_SPEED;
        multi_res.negative  = (sys_bytes[13] != 8'h00);
        multi_res.magnitude = {16'd0, sys_bytes[14], sys_bytes[15]};
      end
      4'd6: begin
        multi_res.field_id  = FID_POSITION;
        multi_res.negative  = (sys_bytes[16] != 8'h00);
        multi_res.magnitude = {sys_bytes[17], sys_bytes[18], sys_bytes[19], sys_bytes[20]};
      end
      4'd7: begin
        multi_res.field_id  = FID_ERROR;
        multi_res.negative  = (sys_bytes[21] != 8'h00);
        multi_res.magnitude = {sys_bytes[22], sys_bytes[23], sys_bytes[24], sys_bytes[25]};
      end
      4'd8: begin
        multi_res.field_id  = FID_READY;
        multi_res.magnitude = {24'd0, sys_bytes[26]};
      end
      default: begin
        multi_res.field_id  = FID_MOTOR;
        multi_res.magnitude = {24'd0, sys_bytes[27]};
      end
    endcase
  end

  assign beat = job_multi_r ? multi_res : job_res_r;

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_multi_nxt = job_multi_r;
    job_res_nxt   = job_res_r;
    job_idx_nxt   = job_idx_r;
    if (new_job.valid) begin
      job_valid_nxt = 1'b1;
      job_multi_nxt = new_job.multi;
      job_res_nxt   = new_job.res;
      job_idx_nxt   = '0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (load) begin
      job_idx_nxt = job_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_multi_r <= job_multi_nxt;
    job_res_r   <= job_res_nxt;
    job_idx_r   <= job_idx_nxt;
    if (load) begin
      out_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SRFP_ASSERT_NOW(a_sys_idx_range, job_valid_r && job_multi_r, job_idx_r <= SYS_LAST_IDX)
  `SRFP_ASSERT_NEXT(a_sys_beats_back_to_back, out_valid && out_ready && !out_data.last, out_valid && $stable(out_data.func_code))
  `SRFP_ASSERT_NEXT(a_single_beat_last, load && !job_multi_r, out_valid && out_data.last)

endmodule
